### rtl/core/xmpcd_pkg.sv
// shared types, constants and translation functions of the xm pattern cell decoder
package xmpcd_pkg;

	localparam int MaxChannels = 32;
	localparam int MaxRows     = 256;

	localparam logic [7:0] CodeEmpty = 8'hFF;
	localparam logic [7:0] CodeOff   = 8'hFE;
	localparam logic [7:0] NoteOffIn = 8'd97;
	localparam logic [7:0] NoteBias  = 8'd11;

	localparam logic [0:0] RegChannelCount = 1'b0;
	localparam logic [0:0] RegRowCount     = 1'b1;

	// raw fields of one finished cell, handed from front to back
	typedef struct packed {
		logic [7:0] note;
		logic [7:0] ins;
		logic [7:0] vol;
		logic [7:0] cmd;
		logic [7:0] par;
	} cell_t;

	typedef struct packed {
		logic [7:0] note;
		logic [7:0] ins;
		logic [7:0] vol;
		logic [7:0] cmd;
		logic [7:0] par;
	} code_t;

	function automatic logic [7:0] low9(input logic [3:0] v);
		low9 = (v > 4'd9) ? 8'd9 : {4'd0, v};
	endfunction

	// lo*65/15 and lo*9/15 for lo in 0..15, as small tables
	function automatic logic [7:0] vol_c_tab(input logic [3:0] lo);
		unique case (lo)
			4'd0:  vol_c_tab = 8'd0;
			4'd1:  vol_c_tab = 8'd4;
			4'd2:  vol_c_tab = 8'd8;
			4'd3:  vol_c_tab = 8'd13;
			4'd4:  vol_c_tab = 8'd17;
			4'd5:  vol_c_tab = 8'd21;
			4'd6:  vol_c_tab = 8'd26;
			4'd7:  vol_c_tab = 8'd30;
			4'd8:  vol_c_tab = 8'd34;
			4'd9:  vol_c_tab = 8'd39;
			4'd10: vol_c_tab = 8'd43;
			4'd11: vol_c_tab = 8'd47;
			4'd12: vol_c_tab = 8'd52;
			4'd13: vol_c_tab = 8'd56;
			4'd14: vol_c_tab = 8'd60;
			default: vol_c_tab = 8'd65;
		endcase
	endfunction

	function automatic logic [7:0] vol_f_tab(input logic [3:0] lo);
		unique case (lo)
			4'd0, 4'd1:   vol_f_tab = 8'd0;
			4'd2, 4'd3:   vol_f_tab = 8'd1;
			4'd4:         vol_f_tab = 8'd2;
			4'd5, 4'd6:   vol_f_tab = 8'd3;
			4'd7, 4'd8:   vol_f_tab = 8'd4;
			4'd9:         vol_f_tab = 8'd5;
			4'd10, 4'd11: vol_f_tab = 8'd6;
			4'd12, 4'd13: vol_f_tab = 8'd7;
			4'd14:        vol_f_tab = 8'd8;
			default:      vol_f_tab = 8'd9;
		endcase
	endfunction

	function automatic logic [7:0] map_volume(input logic [7:0] v);
		logic [3:0] lo;
		lo = v[3:0];
		unique case (v[7:4])
			4'h0:                   map_volume = v;
			4'h1, 4'h2, 4'h3, 4'h4: map_volume = v - 8'h10;
			4'h6:                   map_volume = low9(lo) + 8'd95;
			4'h7:                   map_volume = low9(lo) + 8'd85;
			4'h8:                   map_volume = low9(lo) + 8'd75;
			4'h9:                   map_volume = low9(lo) + 8'd65;
			4'hB:                   map_volume = low9(lo) + 8'd203;
			4'hC:                   map_volume = 8'd128 + vol_c_tab(lo);
			4'hF:                   map_volume = 8'd193 + vol_f_tab(lo);
			default:                map_volume = CodeEmpty;
		endcase
	endfunction

	function automatic code_t translate(input cell_t c);
		code_t      r;
		logic [3:0] lo;
		r  = code_t'(c);
		lo = c.par[3:0];
		if (c.note != CodeEmpty)
			r.note = (c.note == NoteOffIn) ? CodeOff : c.note + NoteBias;
		if (c.ins != CodeEmpty)
			r.ins = (c.ins != 8'd0 && c.ins < 8'd100) ? c.ins - 8'd1 : CodeEmpty;
		if (c.vol != CodeEmpty)
			r.vol = map_volume(c.vol);
		if (c.cmd != CodeEmpty) begin
			unique case (c.cmd)
				8'd0:  r.cmd = 8'd9;
				8'd1:  r.cmd = 8'd5;
				8'd2:  r.cmd = 8'd4;
				8'd3:  r.cmd = 8'd6;
				8'd4:  r.cmd = 8'd7;
				8'd5:  r.cmd = 8'd11;
				8'd6:  r.cmd = 8'd10;
				8'd7:  r.cmd = 8'd17;
				8'd8:  r.cmd = 8'd23;
				8'd9:  r.cmd = 8'd14;
				8'd10: r.cmd = 8'd3;
				8'd11: r.cmd = 8'd1;
				8'd12: r.cmd = 8'd12;
				8'd13: r.cmd = 8'd2;
				8'd14: begin
					r.cmd = 8'd18;
					if (c.par[7:4] == 4'h1 || c.par[7:4] == 4'h2 || c.par[7:4] == 4'h9 ||
						c.par[7:4] == 4'hA || c.par[7:4] == 4'hB) begin
						if (lo == 4'd0) begin
							r.cmd = CodeEmpty;
							r.par = 8'd0;
						end else begin
							unique case (c.par[7:4])
								4'h1: begin r.cmd = 8'd5;  r.par = {4'hF, lo}; end
								4'h2: begin r.cmd = 8'd4;  r.par = {4'hF, lo}; end
								4'h9: begin r.cmd = 8'd16; r.par = {4'h0, lo}; end
								4'hA: begin r.cmd = 8'd3;  r.par = {lo, 4'hF}; end
								default: begin r.cmd = 8'd3; r.par = {4'hF, lo}; end
							endcase
						end
					end
				end
				8'd15: r.cmd = (c.par < 8'd32) ? 8'd0 : 8'd19;
				8'd16: r.cmd = 8'd21;
				8'd17: r.cmd = 8'd22;
				8'd20: begin
					// an already translated note that lands on the empty code also turns off
					if (r.note == CodeEmpty) r.note = CodeOff;
					r.cmd = CodeEmpty;
				end
				8'd25: r.cmd = 8'd15;
				8'd27: r.cmd = 8'd16;
				8'd29: r.cmd = 8'd8;
				default: r.cmd = CodeEmpty;
			endcase
		end
		translate = r;
	endfunction

endpackage

### rtl/core/xmpcd_front.sv
// front end: gathers packed bytes into finished cells
module xmpcd_front import xmpcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [7:0]  packed_byte,
	output logic        in_stall,
	output logic        cell_valid,
	output cell_t       cell_data,
	input  logic        cell_stall
);
	logic [4:0] pend_q;
	cell_t      cell_q;
	logic       acc;
	logic [4:0] pend_nxt;
	cell_t      cell_nxt;
	logic       done;
	logic [4:0] first;

	assign in_stall = cell_stall;
	assign acc      = in_valid && !in_stall;
	assign first    = pend_q & (~pend_q + 5'd1);

	always_comb begin
		cell_nxt = cell_q;
		pend_nxt = pend_q;
		if (pend_q == 5'd0) begin
			cell_nxt = '{note: CodeEmpty, ins: CodeEmpty, vol: CodeEmpty,
				cmd: CodeEmpty, par: 8'd0};
			if (!packed_byte[7]) begin
				cell_nxt.note = packed_byte;
				pend_nxt      = 5'h1E;
			end else begin
				pend_nxt = packed_byte[4:0];
			end
		end else begin
			if (first[0]) cell_nxt.note = packed_byte;
			if (first[1]) cell_nxt.ins  = packed_byte;
			if (first[2]) cell_nxt.vol  = packed_byte;
			if (first[3]) cell_nxt.cmd  = packed_byte;
			if (first[4]) cell_nxt.par  = packed_byte;
			pend_nxt = pend_q & ~first;
		end
		done = (pend_nxt == 5'd0);
	end

	// a finished cell goes straight to the queue
	assign cell_valid = acc && done;
	assign cell_data  = cell_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 5'd0;
		end else if (acc) begin
			pend_q <= pend_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) cell_q <= cell_nxt;
	end
endmodule

### rtl/core/xmpcd_queue.sv
// two-entry queue between front and back ends
module xmpcd_queue import xmpcd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_valid,
	input  cell_t wr_cell,
	output logic  full,
	output logic  rd_valid,
	output cell_t rd_cell,
	input  logic  rd_take
);
	cell_t      mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign full     = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_cell  = mem_q[rp_q];
	assign wr       = wr_valid && !full;
	assign rd       = rd_take && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_cell;
	end
endmodule

### rtl/core/xmpcd_back.sv
// back end: translates cells, tracks channel and row, holds the output register
module xmpcd_back import xmpcd_pkg::*; #(
	parameter int MAX_CHANNELS = MaxChannels,
	parameter int MAX_ROWS     = MaxRows
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        q_valid,
	input  cell_t       q_cell,
	output logic        q_take,
	output logic        out_valid,
	input  logic        out_stall,
	output code_t       code,
	output logic [4:0]  channel_index,
	output logic [7:0]  row_index,
	output logic        pattern_done
);
	localparam int CW = $clog2(MAX_CHANNELS + 1);
	localparam int RW = $clog2(MAX_ROWS + 1);

	logic [5:0]    chan_cnt_q;
	logic [8:0]    row_cnt_q;
	logic [CW-1:0] chan_q;
	logic [RW-1:0] row_q;
	logic          ov_q;
	logic [CW-1:0] chans, chan_inc;
	logic [RW-1:0] rows, row_inc;
	logic          wrap_c, wrap_r;

	always_comb begin
		if (chan_cnt_q == 6'd0) chans = CW'(1);
		else if (7'(chan_cnt_q) > 7'(MAX_CHANNELS)) chans = CW'(MAX_CHANNELS);
		else chans = CW'(chan_cnt_q);
		if (row_cnt_q == 9'd0) rows = RW'(1);
		else if (10'(row_cnt_q) > 10'(MAX_ROWS)) rows = RW'(MAX_ROWS);
		else rows = RW'(row_cnt_q);
		chan_inc = chan_q + CW'(1);
		row_inc  = row_q + RW'(1);
		wrap_c   = chan_inc >= chans;
		wrap_r   = row_inc >= rows;
	end

	assign q_take    = q_valid && (!ov_q || !out_stall);
	assign out_valid = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_cnt_q <= 6'd8;
			row_cnt_q  <= 9'd64;
			chan_q     <= '0;
			row_q      <= '0;
			ov_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					RegChannelCount: chan_cnt_q <= cfg_data[5:0];
					RegRowCount:     row_cnt_q  <= cfg_data;
					default: ;
				endcase
			end
			if (q_take) begin
				ov_q <= 1'b1;
				if (wrap_c) begin
					chan_q <= '0;
					row_q  <= wrap_r ? '0 : row_inc;
				end else begin
					chan_q <= chan_inc;
				end
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_take) begin
			code          <= translate(q_cell);
			channel_index <= 5'(chan_q);
			row_index     <= 8'(row_q);
			pattern_done  <= wrap_c && wrap_r;
		end
	end
endmodule

### rtl/core/xm_pattern_cell_decoder_core.sv
// top level of the packed xm pattern cell decoder
// usage:
// - input channel: in_valid / in_stall with packed_byte, one byte of packed
//   pattern data per item; an item is taken when in_valid is high and
//   in_stall low
// - output channel: out_valid / out_stall with one decoded cell per item,
//   carrying its translated fields, its channel, its row and pattern_done on
//   the last cell of the pattern
// - configuration: cfg_we, cfg_index, cfg_data write channel_count (index 0)
//   and row_count (index 1); write only while the block is idle
// - throughput: one byte per cycle while in_stall is low; a byte that ends a
//   cell passes the queue, then the output register, before it is shown
// - the front end gathers bytes into cells, a two-entry queue decouples it
//   from the back end, which translates and walks channel and row counters
// - the front end stalls only when the queue is full, so a stalled receiver
//   backs up into the input after the queue and output register fill
// - reset clears the field mask, counters and queue, and loads channel_count
//   8 and row_count 64
module xm_pattern_cell_decoder_core import xmpcd_pkg::*; #(
	parameter int MAX_CHANNELS = MaxChannels,
	parameter int MAX_ROWS     = MaxRows
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [8:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] packed_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] note_code,
	output logic [7:0] instrument_code,
	output logic [7:0] volume_code,
	output logic [7:0] command_code,
	output logic [7:0] parameter_value,
	output logic [4:0] channel_index,
	output logic [7:0] row_index,
	output logic       pattern_done
);
	// front to queue
	logic  f_valid, q_full;
	cell_t f_cell;
	// queue to back
	logic  q_valid, q_take;
	cell_t q_cell;
	code_t code;

	xmpcd_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .packed_byte(packed_byte), .in_stall(in_stall),
		.cell_valid(f_valid), .cell_data(f_cell), .cell_stall(q_full)
	);

	xmpcd_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_cell(f_cell), .full(q_full),
		.rd_valid(q_valid), .rd_cell(q_cell), .rd_take(q_take)
	);

	xmpcd_back #(.MAX_CHANNELS(MAX_CHANNELS), .MAX_ROWS(MAX_ROWS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.q_valid(q_valid), .q_cell(q_cell), .q_take(q_take),
		.out_valid(out_valid), .out_stall(out_stall), .code(code),
		.channel_index(channel_index), .row_index(row_index),
		.pattern_done(pattern_done)
	);

	// unpack the translated cell onto its ports
	assign note_code       = code.note;
	assign instrument_code = code.ins;
	assign volume_code     = code.vol;
	assign command_code    = code.cmd;
	assign parameter_value = code.par;
endmodule

### rtl/core/xmpcd_checker.sv
// port-level checker for the decoder, bound to the top level
module xmpcd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] note_code,
	input logic [4:0] channel_index,
	input logic       pattern_done
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(note_code))
		else $error("stalled item changed");

	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	a_done_chan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && pattern_done |=> !out_valid || channel_index == 5'd0)
		else $error("pattern did not restart at channel zero");

	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("output valid after reset");
endmodule

bind xm_pattern_cell_decoder_core xmpcd_checker u_xmpcd_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .note_code(note_code),
	.channel_index(channel_index), .pattern_done(pattern_done)
);
